FILE: hdl/tlc_pkg.sv
// Shared constants and register index codes for the thin-lens camera ray generator.
package tlc_pkg;

   // Default geometry of the position format.
   localparam int COORD_WIDTH_DEF = 20;
   localparam int FRAC_BITS_DEF   = 12;

   // Fixed widths of the input and result fields.
   localparam int APER_WIDTH = 19;
   localparam int ST_WIDTH   = 17;
   localparam int ST_SHIFT   = 16;
   localparam int RAND_WIDTH = 16;
   localparam int DIR_WIDTH  = 20;
   localparam int DIR_FRAC   = 18;

   // Lens offset scaling: rand * aperture, rounded back by the Q1.15 weight.
   localparam int LENS_SHIFT = 15;
   localparam int PROD_WIDTH = RAND_WIDTH + APER_WIDTH + 1;
   localparam int RD_WIDTH   = PROD_WIDTH - LENS_SHIFT;

   // Normalisation: the largest magnitude is brought to [2^29, 2^30).
   localparam int NORM_MSB    = 29;
   localparam int NORM_WIDTH  = 30;
   localparam int SUM_WIDTH   = 2 * NORM_WIDTH + 2;
   localparam int SQRT_WIDTH  = SUM_WIDTH + 1;
   localparam int SQRT_STEPS  = 31;
   localparam int LEN_WIDTH   = 31;
   localparam int QUO_WIDTH   = DIR_FRAC + 1;
   localparam int DIV_STEPS   = QUO_WIDTH;
   localparam int NUM_WIDTH   = NORM_WIDTH + DIR_FRAC + 1;

   // Decoupling queue between the front and back halves.
   localparam int QUEUE_DEPTH = 4;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_EYE_POINT         = 3'd0,
      REG_BASIS_U           = 3'd1,
      REG_BASIS_V           = 3'd2,
      REG_LOWER_LEFT_CORNER = 3'd3,
      REG_HORIZONTAL_SPAN   = 3'd4,
      REG_VERTICAL_SPAN     = 3'd5,
      REG_HALF_APERTURE     = 3'd6
   } csr_index_type;

endpackage

FILE: hdl/tlc_front.sv
// Front half: configuration registers, lens offset, ray origin and unnormalised direction.
module tlc_front #(
   parameter int COORD_WIDTH = tlc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tlc_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_en,
   input  logic [tlc_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [3*COORD_WIDTH-1:0]                 csr_wdata,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [tlc_pkg::ST_WIDTH-1:0]             req_screen_s,
   input  logic [tlc_pkg::ST_WIDTH-1:0]             req_screen_t,
   input  logic signed [tlc_pkg::RAND_WIDTH-1:0]    req_lens_rand_x,
   input  logic signed [tlc_pkg::RAND_WIDTH-1:0]    req_lens_rand_y,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [3*COORD_WIDTH-1:0]                 out_origin,
   output logic [3*(COORD_WIDTH+tlc_pkg::ST_WIDTH+3)-1:0] out_dir
);
   import tlc_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PW  = W + RD_WIDTH;
   localparam int SW  = PW + 1;
   localparam int EW  = SW + 1;
   localparam int HW  = W + ST_WIDTH + 1;
   localparam int HV  = HW + 1;
   localparam int DW  = W + ST_WIDTH + 3;
   localparam int NFS = 6;
   localparam logic signed [SW-1:0] RND_F = SW'(1) <<< (F - 1);
   localparam logic signed [PROD_WIDTH-1:0] RND_L = PROD_WIDTH'(1) <<< (LENS_SHIFT - 1);
   localparam logic signed [EW-1:0] SAT_HI = EW'((1 <<< (W - 1)) - 1);
   localparam logic signed [EW-1:0] SAT_LO = EW'(-(1 <<< (W - 1)));

   // Configuration registers.
   logic [3*W-1:0]          eye_ff, bu_ff, bv_ff, llc_ff, hspan_ff, vspan_ff;
   logic [APER_WIDTH-1:0]   aper_ff;

   // Pipeline registers.
   logic [NFS-1:0]                 fvld_ff;
   logic signed [PROD_WIDTH-1:0]   prx_ff, pry_ff, prx_in, pry_in;
   logic [ST_WIDTH-1:0]            s1_ff, t1_ff, s2_ff, t2_ff;
   logic signed [PROD_WIDTH-1:0]   rxr, ryr;
   logic signed [RD_WIDTH-1:0]     rdx_ff, rdy_ff, rdx_in, rdy_in;
   logic signed [PW-1:0]           pu_ff [3], pv_ff [3], pu_in [3], pv_in [3];
   logic signed [HW-1:0]           hs_ff [3], vt_ff [3], hs_in [3], vt_in [3];
   logic signed [SW-1:0]           rsum [3];
   logic signed [SW-1:0]           off_ff [3], off_in [3];
   logic signed [HV-1:0]           hv_ff [3], hv_in [3], hv5_ff [3];
   logic signed [EW-1:0]           esum [3];
   logic signed [W-1:0]            org_ff [3], org_in [3], org6_ff [3];
   logic signed [DW-1:0]           dif [3];
   logic signed [DW-1:0]           d_ff [3], d_in [3];
   logic                           adv;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff   <= '0;
         bu_ff    <= '0;
         bv_ff    <= '0;
         llc_ff   <= '0;
         hspan_ff <= '0;
         vspan_ff <= '0;
         aper_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_EYE_POINT:         eye_ff   <= csr_wdata;
            REG_BASIS_U:           bu_ff    <= csr_wdata;
            REG_BASIS_V:           bv_ff    <= csr_wdata;
            REG_LOWER_LEFT_CORNER: llc_ff   <= csr_wdata;
            REG_HORIZONTAL_SPAN:   hspan_ff <= csr_wdata;
            REG_VERTICAL_SPAN:     vspan_ff <= csr_wdata;
            REG_HALF_APERTURE:     aper_ff  <= csr_wdata[APER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The whole front pipeline moves unless its last item cannot enter the queue.
   assign adv       = !fvld_ff[NFS-1] || out_ready;
   assign req_ready = adv;
   assign out_valid = fvld_ff[NFS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= '0;
      end else if (adv) begin
         fvld_ff <= {fvld_ff[NFS-2:0], req_valid};
      end
   end

   // Next values of every stage.
   always_comb begin
      // Lens random values scaled by the aperture radius.
      prx_in = $signed(req_lens_rand_x) * $signed({1'b0, aper_ff});
      pry_in = $signed(req_lens_rand_y) * $signed({1'b0, aper_ff});
      // Round back to position units.
      rxr    = prx_ff + RND_L;
      ryr    = pry_ff + RND_L;
      rdx_in = rxr[PROD_WIDTH-1:LENS_SHIFT];
      rdy_in = ryr[PROD_WIDTH-1:LENS_SHIFT];
      for (int i = 0; i < 3; i++) begin
         // Basis products and focus-plane products.
         pu_in[i]  = $signed(bu_ff[i*W +: W]) * rdx_ff;
         pv_in[i]  = $signed(bv_ff[i*W +: W]) * rdy_ff;
         hs_in[i]  = $signed(hspan_ff[i*W +: W]) * $signed({1'b0, s2_ff});
         vt_in[i]  = $signed(vspan_ff[i*W +: W]) * $signed({1'b0, t2_ff});
         // Rounded lens offset.
         rsum[i]   = SW'(pu_ff[i]) + SW'(pv_ff[i]) + RND_F;
         off_in[i] = rsum[i] >>> F;
         hv_in[i]  = HV'(hs_ff[i]) + HV'(vt_ff[i]);
         // Saturated origin.
         esum[i]   = EW'($signed(eye_ff[i*W +: W])) + EW'(off_ff[i]);
         if (esum[i] > SAT_HI) begin
            org_in[i] = W'(SAT_HI);
         end else if (esum[i] < SAT_LO) begin
            org_in[i] = W'(SAT_LO);
         end else begin
            org_in[i] = esum[i][W-1:0];
         end
         // Direction towards the focus-plane point, exact.
         dif[i]  = DW'($signed(llc_ff[i*W +: W])) - DW'(org_ff[i]);
         d_in[i] = (dif[i] <<< ST_SHIFT) + DW'(hv5_ff[i]);
      end
   end

   // Stage registers advance together.
   always_ff @(posedge clock) begin
      if (adv) begin
         prx_ff <= prx_in;
         pry_ff <= pry_in;
         s1_ff  <= req_screen_s;
         t1_ff  <= req_screen_t;
         rdx_ff <= rdx_in;
         rdy_ff <= rdy_in;
         s2_ff  <= s1_ff;
         t2_ff  <= t1_ff;
         for (int i = 0; i < 3; i++) begin
            pu_ff[i]   <= pu_in[i];
            pv_ff[i]   <= pv_in[i];
            hs_ff[i]   <= hs_in[i];
            vt_ff[i]   <= vt_in[i];
            off_ff[i]  <= off_in[i];
            hv_ff[i]   <= hv_in[i];
            org_ff[i]  <= org_in[i];
            hv5_ff[i]  <= hv_ff[i];
            d_ff[i]    <= d_in[i];
            org6_ff[i] <= org_ff[i];
         end
      end
   end

   assign out_origin = {org6_ff[2], org6_ff[1], org6_ff[0]};
   assign out_dir    = {d_ff[2], d_ff[1], d_ff[0]};

endmodule

FILE: hdl/tlc_queue.sv
// Short item queue that decouples the front half from the back half.
module tlc_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = tlc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_data
);
   import tlc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]         wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: hdl/tlc_back.sv
// Back half: direction normalisation through a pipelined square root and divider.
module tlc_back #(
   parameter int COORD_WIDTH = tlc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [3*COORD_WIDTH-1:0]                 in_origin,
   input  logic [3*(COORD_WIDTH+tlc_pkg::ST_WIDTH+3)-1:0] in_dir,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [COORD_WIDTH-1:0]            rsp_origin_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_origin_y,
   output logic signed [COORD_WIDTH-1:0]            rsp_origin_z,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]     rsp_dir_x,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]     rsp_dir_y,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]     rsp_dir_z,
   output logic                                     rsp_degenerate
);
   import tlc_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + ST_WIDTH + 3;
   localparam int NG  = (DW + 7) / 8;
   localparam int PSW = $clog2(NG * 8);
   localparam int SQQ = 2 * NORM_WIDTH;
   localparam int S_SQ0 = 5;
   localparam int S_DV0 = S_SQ0 + SQRT_STEPS + 1;
   // The last stage registers the signed direction after the final quotient bit.
   localparam int NBS = S_DV0 + DIV_STEPS + 2;

   typedef struct packed {
      logic [2:0]     neg;
      logic           degen;
      logic [3*W-1:0] org;
   } side_type;

   logic                    adv;
   logic [NBS-1:0]          vld_ff;
   side_type                side_ff [NBS];
   side_type                side_in;

   logic [DW-1:0]           d_u [3];
   logic [DW-1:0]           a_ff [3], a_in [3], a1_ff [3], a2_ff [3];
   logic [DW-1:0]           or_ff, or_in;
   logic [NG*8-1:0]         orp;
   logic [NG-1:0]           nz_ff, nz_in;
   logic [2:0]              loc_ff [NG], loc_in [NG];
   logic [PSW-1:0]          pos_ff, pos_in, rsh, lsh;
   logic [DW-1:0]           shv [3];
   logic [NORM_WIDTH-1:0]   na3_ff [3], na3_in [3], na4_ff [3];
   logic [SQQ-1:0]          sq_ff [3], sq_in [3];
   logic [SUM_WIDTH-1:0]    sum_in;
   logic [SQRT_WIDTH-1:0]   x_ff [SQRT_STEPS+1], res_ff [SQRT_STEPS+1];
   logic [NORM_WIDTH-1:0]   nas_ff [SQRT_STEPS+1][3];
   logic [LEN_WIDTH-1:0]    len;
   logic [NUM_WIDTH-1:0]    dn_ff [DIV_STEPS+1][3];
   logic [LEN_WIDTH-1:0]    dl_ff [DIV_STEPS+1];
   logic [QUO_WIDTH-1:0]    dq_ff [DIV_STEPS+1][3];
   logic signed [DIR_WIDTH-1:0] dir_ff [3], dir_in [3];

   // The whole back pipeline stalls only while a finished result waits.
   assign adv       = !vld_ff[NBS-1] || rsp_ready;
   assign in_ready  = adv;
   assign rsp_valid = vld_ff[NBS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NBS-2:0], in_valid};
      end
   end

   // Magnitudes, signs, degenerate flag and leading-one search.
   always_comb begin
      or_in = '0;
      for (int l = 0; l < 3; l++) begin
         d_u[l]  = in_dir[l*DW +: DW];
         a_in[l] = d_u[l][DW-1] ? (~d_u[l] + DW'(1)) : d_u[l];
         or_in   = or_in | a_in[l];
      end
      side_in.neg   = {d_u[2][DW-1], d_u[1][DW-1], d_u[0][DW-1]};
      side_in.degen = (d_u[0] == '0) && (d_u[1] == '0) && (d_u[2] == '0);
      side_in.org   = in_origin;

      // Leading one of each byte group, then of the whole word.
      orp = (NG*8)'(or_ff);
      for (int g = 0; g < NG; g++) begin
         nz_in[g]  = |orp[g*8 +: 8];
         loc_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (orp[g*8 + b]) begin
               loc_in[g] = 3'(b);
            end
         end
      end
      pos_in = '0;
      for (int g = 0; g < NG; g++) begin
         if (nz_ff[g]) begin
            pos_in = PSW'(g * 8) + PSW'(loc_ff[g]);
         end
      end

      // Shift so that the largest magnitude lands in [2^29, 2^30).
      rsh = pos_ff - PSW'(NORM_MSB);
      lsh = PSW'(NORM_MSB) - pos_ff;
      for (int l = 0; l < 3; l++) begin
         if (pos_ff >= PSW'(NORM_MSB)) begin
            shv[l] = a2_ff[l] >> rsh;
         end else begin
            shv[l] = a2_ff[l] << lsh;
         end
         na3_in[l] = shv[l][NORM_WIDTH-1:0];
         sq_in[l]  = SQQ'(na3_ff[l]) * SQQ'(na3_ff[l]);
      end
      sum_in = SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
   end

   // Front stages of the back half, up to the square root input.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < NBS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         or_ff  <= or_in;
         nz_ff  <= nz_in;
         pos_ff <= pos_in;
         for (int g = 0; g < NG; g++) begin
            loc_ff[g] <= loc_in[g];
         end
         for (int l = 0; l < 3; l++) begin
            a_ff[l]      <= a_in[l];
            a1_ff[l]     <= a_ff[l];
            a2_ff[l]     <= a1_ff[l];
            na3_ff[l]    <= na3_in[l];
            sq_ff[l]     <= sq_in[l];
            na4_ff[l]    <= na3_ff[l];
            nas_ff[0][l] <= na4_ff[l];
         end
         x_ff[0]   <= SQRT_WIDTH'(sum_in);
         res_ff[0] <= '0;
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQRT_WIDTH-1:0] BITV = SQRT_WIDTH'(1) << (2 * (SQRT_STEPS - k));
      logic [SQRT_WIDTH-1:0] trial;
      logic [SQRT_WIDTH-1:0] x_in, res_in;

      always_comb begin
         trial = res_ff[k-1] + BITV;
         if (x_ff[k-1] >= trial) begin
            x_in   = x_ff[k-1] - trial;
            res_in = (res_ff[k-1] >> 1) + BITV;
         end else begin
            x_in   = x_ff[k-1];
            res_in = res_ff[k-1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k]   <= x_in;
            res_ff[k] <= res_in;
            for (int l = 0; l < 3; l++) begin
               nas_ff[k][l] <= nas_ff[k-1][l];
            end
         end
      end
   end

   assign len = res_ff[SQRT_STEPS][LEN_WIDTH-1:0];

   // Divider set-up: rounded numerator for each lane.
   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[0] <= len;
         for (int l = 0; l < 3; l++) begin
            dn_ff[0][l] <= (NUM_WIDTH'(nas_ff[SQRT_STEPS][l]) << DIR_FRAC)
                           + NUM_WIDTH'(len >> 1);
            dq_ff[0][l] <= '0;
         end
      end
   end

   // Restoring division, one quotient bit per stage on three lanes.
   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      logic [NUM_WIDTH-1:0] den;
      logic [NUM_WIDTH-1:0] dn_in [3];
      logic [QUO_WIDTH-1:0] dq_in [3];

      always_comb begin
         den = NUM_WIDTH'(dl_ff[j-1]) << (DIV_STEPS - j);
         for (int l = 0; l < 3; l++) begin
            if (dn_ff[j-1][l] >= den) begin
               dn_in[l] = dn_ff[j-1][l] - den;
               dq_in[l] = dq_ff[j-1][l] | (QUO_WIDTH'(1) << (DIV_STEPS - j));
            end else begin
               dn_in[l] = dn_ff[j-1][l];
               dq_in[l] = dq_ff[j-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dl_ff[j] <= dl_ff[j-1];
            for (int l = 0; l < 3; l++) begin
               dn_ff[j][l] <= dn_in[l];
               dq_ff[j][l] <= dq_in[l];
            end
         end
      end
   end

   // Signs restored; a zero-length direction gives the zero vector.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (side_ff[NBS-2].degen) begin
            dir_in[l] = '0;
         end else if (side_ff[NBS-2].neg[l]) begin
            dir_in[l] = -$signed(DIR_WIDTH'(dq_ff[DIV_STEPS][l]));
         end else begin
            dir_in[l] = $signed(DIR_WIDTH'(dq_ff[DIV_STEPS][l]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            dir_ff[l] <= dir_in[l];
         end
      end
   end

   assign rsp_origin_x   = side_ff[NBS-1].org[0 +: W];
   assign rsp_origin_y   = side_ff[NBS-1].org[W +: W];
   assign rsp_origin_z   = side_ff[NBS-1].org[2*W +: W];
   assign rsp_dir_x      = dir_ff[0];
   assign rsp_dir_y      = dir_ff[1];
   assign rsp_dir_z      = dir_ff[2];
   assign rsp_degenerate = side_ff[NBS-1].degen;

endmodule

FILE: hdl/thin_lens_camera_ray_generator.sv
// Throughput: one item per cycle while rsp_ready stays high; the 31-stage square root
// and the 19-stage divider are fully pipelined, and a four-entry queue lets the front
// and back halves stall apart.
// Reset: synchronous, active high; clears all configuration registers to zero and
// empties the pipelines and the queue. No clearing pass is needed.
module thin_lens_camera_ray_generator #(
   parameter int COORD_WIDTH = tlc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tlc_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [tlc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [3*COORD_WIDTH-1:0]              csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tlc_pkg::ST_WIDTH-1:0]          req_screen_s,
   input  logic [tlc_pkg::ST_WIDTH-1:0]          req_screen_t,
   input  logic signed [tlc_pkg::RAND_WIDTH-1:0] req_lens_rand_x,
   input  logic signed [tlc_pkg::RAND_WIDTH-1:0] req_lens_rand_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_WIDTH-1:0]         rsp_origin_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_origin_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_origin_z,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]  rsp_dir_x,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]  rsp_dir_y,
   output logic signed [tlc_pkg::DIR_WIDTH-1:0]  rsp_dir_z,
   output logic                                  rsp_degenerate
);
   import tlc_pkg::*;

   localparam int DW = COORD_WIDTH + ST_WIDTH + 3;
   localparam int QW = 3 * COORD_WIDTH + 3 * DW;
   localparam logic signed [DIR_WIDTH-1:0] DIR_ONE = DIR_WIDTH'(1) <<< DIR_FRAC;

   logic                     fe_valid, fe_ready, bk_valid, bk_ready;
   logic [3*COORD_WIDTH-1:0] fe_origin, bk_origin;
   logic [3*DW-1:0]          fe_dir, bk_dir;

   // Front half: origin and raw direction.
   tlc_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_screen_s    (req_screen_s),
      .req_screen_t    (req_screen_t),
      .req_lens_rand_x (req_lens_rand_x),
      .req_lens_rand_y (req_lens_rand_y),
      .out_valid       (fe_valid),
      .out_ready       (fe_ready),
      .out_origin      (fe_origin),
      .out_dir         (fe_dir)
   );

   // Queue between the halves.
   tlc_queue #(
      .DATA_WIDTH (QW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   ({fe_origin, fe_dir}),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  ({bk_origin, bk_dir})
   );

   // Back half: normalisation.
   tlc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (bk_valid),
      .in_ready       (bk_ready),
      .in_origin      (bk_origin),
      .in_dir         (bk_dir),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_origin_x   (rsp_origin_x),
      .rsp_origin_y   (rsp_origin_y),
      .rsp_origin_z   (rsp_origin_z),
      .rsp_dir_x      (rsp_dir_x),
      .rsp_dir_y      (rsp_dir_y),
      .rsp_dir_z      (rsp_dir_z),
      .rsp_degenerate (rsp_degenerate)
   );

   // A degenerate item carries the zero vector.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0)
      else $error("degenerate item with non-zero direction");

   // A proper direction is never the zero vector.
   a_dir_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_dir_x != '0 || rsp_dir_y != '0 || rsp_dir_z != '0)
      else $error("non-degenerate item with zero direction");

   // Direction components stay within one in magnitude.
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_x <= DIR_ONE && rsp_dir_x >= -DIR_ONE
                 && rsp_dir_y <= DIR_ONE && rsp_dir_y >= -DIR_ONE
                 && rsp_dir_z <= DIR_ONE && rsp_dir_z >= -DIR_ONE)
      else $error("direction component beyond unit range");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the thin-lens camera ray generator.
module testbench;
   import tlc_pkg::*;

   localparam int CW = 20;
   localparam int FB = 12;

   // One expected ray.
   typedef struct {
      logic signed [CW-1:0]        ox, oy, oz;
      logic signed [DIR_WIDTH-1:0] dx, dy, dz;
      logic                        degen;
   } ray_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [3*CW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ST_WIDTH-1:0] req_screen_s = '0;
   logic [ST_WIDTH-1:0] req_screen_t = '0;
   logic signed [RAND_WIDTH-1:0] req_lens_rand_x = '0;
   logic signed [RAND_WIDTH-1:0] req_lens_rand_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic signed [DIR_WIDTH-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic rsp_degenerate;

   thin_lens_camera_ray_generator dut (.*);

   // Shadow copy of the camera registers.
   logic [3*CW-1:0] cam_regs [6];
   logic [APER_WIDTH-1:0] lens_radius;

   ray_type pending_rays [$];
   int   fail_count = 0;
   int   rays_checked = 0;
   int   degenerate_seen = 0;
   bit   rsp_idle_enable = 1'b1;
   bit   req_idle_enable = 1'b1;
   bit   hold_off_rsp = 1'b0;

   initial forever #10 clock = ~clock;

   initial begin
      #100000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic longint comp(int r, int i);
      logic signed [CW-1:0] c;
      c = cam_regs[r][i*CW +: CW];
      return longint'(c);
   endfunction

   // floor((x + 2^(n-1)) / 2^n) via arithmetic shift.
   function automatic longint rnd_shift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Works out the ray that one sample should produce.
   function automatic ray_type trace_ray(logic [16:0] s, logic [16:0] t,
                                         logic signed [15:0] rx, logic signed [15:0] ry);
      ray_type r;
      longint rdx, rdy, off, hi, lo, q, len;
      longint p [3];
      longint d [3];
      longint unsigned a [3];
      longint unsigned m, sum;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      rdx = rnd_shift(longint'(rx) * longint'(lens_radius), 15);
      rdy = rnd_shift(longint'(ry) * longint'(lens_radius), 15);
      m = 0;
      for (int i = 0; i < 3; i++) begin
         off = rnd_shift(comp(1, i) * rdx + comp(2, i) * rdy, FB);
         p[i] = comp(0, i) + off;
         if (p[i] > hi) p[i] = hi;
         if (p[i] < lo) p[i] = lo;
         d[i] = (comp(3, i) - p[i]) * 65536 + comp(4, i) * longint'(s)
                + comp(5, i) * longint'(t);
         a[i] = d[i] < 0 ? longint'(-d[i]) : d[i];
         if (a[i] > m) m = a[i];
      end
      r.ox = p[0][CW-1:0];
      r.oy = p[1][CW-1:0];
      r.oz = p[2][CW-1:0];
      r.dx = '0; r.dy = '0; r.dz = '0;
      r.degen = (m == 0);
      if (m != 0) begin
         while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
         end
         sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
         len = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((a[i] << DIR_FRAC) + (len >> 1)) / len;
            if (d[i] < 0) q = -q;
            if (i == 0) r.dx = q[DIR_WIDTH-1:0];
            else if (i == 1) r.dy = q[DIR_WIDTH-1:0];
            else r.dz = q[DIR_WIDTH-1:0];
         end
      end
      return r;
   endfunction

   // Writes one register and mirrors it; only called while the block is idle.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [3*CW-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx < REG_HALF_APERTURE) cam_regs[idx] = val;
      else if (idx == REG_HALF_APERTURE) lens_radius = val[APER_WIDTH-1:0];
   endtask

   function automatic logic [3*CW-1:0] pack3(int x, int y, int z);
      logic [CW-1:0] a, b, c;
      a = CW'(x); b = CW'(y); c = CW'(z);
      return {c, b, a};
   endfunction

   // Sends one sample; valid stays high between back-to-back items.
   task automatic send_sample(logic [16:0] s, logic [16:0] t,
                              logic signed [15:0] rx, logic signed [15:0] ry);
      if (req_idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_screen_s <= s;
      req_screen_t <= t;
      req_lens_rand_x <= rx;
      req_lens_rand_y <= ry;
      do @(posedge clock); while (!req_ready);
      pending_rays.push_back(trace_ray(s, t, rx, ry));
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Waits until the block has delivered everything and drained its pipeline.
   task automatic drain();
      int guard;
      stop_sending();
      guard = 0;
      while (pending_rays.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic send_random(int n, bit wild);
      logic [16:0] s, t;
      for (int i = 0; i < n; i++) begin
         s = wild ? 17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536));
         t = wild ? 17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536));
         send_sample(s, t, 16'($urandom), 16'($urandom));
      end
   endtask

   // Result checker, with random and long receiver stalls.
   always @(posedge clock) begin
      ray_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rays.size() == 0) begin
            $display("%0t: unexpected ray", $time);
            fail_count++;
         end else begin
            e = pending_rays.pop_front();
            rays_checked++;
            if (rsp_degenerate) degenerate_seen++;
            if ({rsp_origin_x, rsp_origin_y, rsp_origin_z} !== {e.ox, e.oy, e.oz}) begin
               $display("%0t: origin expected %0d %0d %0d actual %0d %0d %0d", $time,
                        e.ox, e.oy, e.oz, rsp_origin_x, rsp_origin_y, rsp_origin_z);
               fail_count++;
            end
            if ({rsp_dir_x, rsp_dir_y, rsp_dir_z} !== {e.dx, e.dy, e.dz}) begin
               $display("%0t: direction expected %0d %0d %0d actual %0d %0d %0d", $time,
                        e.dx, e.dy, e.dz, rsp_dir_x, rsp_dir_y, rsp_dir_z);
               fail_count++;
            end
            if (rsp_degenerate !== e.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        e.degen, rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall bursts, or a long hold-off on request.
   initial begin
      forever begin
         if (hold_off_rsp) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_off_rsp = 1'b0;
         end else if (rsp_idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Directed edges: zero registers, degenerate rays, extremes of the fields.
   task automatic test_directed();
      write_reg(REG_EYE_POINT, pack3(0, 0, 4096));
      write_reg(REG_BASIS_U, pack3(4096, 0, 0));
      write_reg(REG_BASIS_V, pack3(0, 4096, 0));
      write_reg(REG_LOWER_LEFT_CORNER, pack3(-8192, -8192, 0));
      write_reg(REG_HORIZONTAL_SPAN, pack3(16384, 0, 0));
      write_reg(REG_VERTICAL_SPAN, pack3(0, 16384, 0));
      write_reg(REG_HALF_APERTURE, (3*CW)'(19'd0));
      write_reg(3'd7, '1);
      // Centre of the screen with no aperture looks straight down the z axis.
      send_sample(17'd32768, 17'd32768, 16'sd0, 16'sd0);
      send_sample(17'd0, 17'd0, 16'sd0, 16'sd0);
      send_sample(17'd65536, 17'd65536, 16'sd32767, -16'sd32767);
      send_sample(17'd131071, 17'd131071, 16'sh8000, 16'sh8000);
      drain();
      write_reg(REG_HALF_APERTURE, (3*CW)'(19'h7FFFF));
      write_reg(REG_EYE_POINT, pack3(524287, -524288, 524287));
      write_reg(REG_BASIS_U, pack3(524287, -524288, 524287));
      write_reg(REG_BASIS_V, pack3(-524288, 524287, -524288));
      send_sample(17'd0, 17'd65536, 16'sd32767, 16'sd32767);
      send_sample(17'd65536, 17'd0, 16'sh8000, 16'sd32767);
      send_sample(17'd131071, 17'd0, -16'sd32767, 16'sh8000);
      send_sample(17'd1, 17'd131071, 16'sd1, -16'sd1);
      drain();
      // All registers but the half aperture zero again: every ray is degenerate at the origin.
      for (int r = 0; r < 6; r++) write_reg(CSR_INDEX_WIDTH'(r), '0);
      send_sample(17'd12345, 17'd54321, 16'sd100, -16'sd100);
      drain();
   endtask

   // Random samples over a few random camera set-ups.
   task automatic test_random_cameras();
      for (int ph = 0; ph < 4; ph++) begin
         for (int r = 0; r < 6; r++)
            write_reg(CSR_INDEX_WIDTH'(r), (ph == 3) ? (3*CW)'({$urandom, $urandom}) :
                         pack3($urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768));
         write_reg(REG_HALF_APERTURE, (3*CW)'($urandom_range(0, 8191)));
         send_random(110, ph == 3);
         drain();
      end
   endtask

   // Receiver holds off while the sender keeps offering, filling the block.
   task automatic test_back_pressure();
      hold_off_rsp = 1'b1;
      send_random(100, 1'b0);
      drain();
   endtask

   // Final stretch with no idling on either side.
   task automatic test_full_rate();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      send_random(90, 1'b1);
      drain();
   endtask

   initial begin
      for (int r = 0; r < 6; r++) cam_regs[r] = '0;
      lens_radius = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_cameras();
      test_back_pressure();
      test_full_rate();
      if (pending_rays.size() != 0) begin
         $display("%0d rays never arrived", pending_rays.size());
         fail_count++;
      end
      $display("Checked %0d rays (%0d degenerate) over several camera set-ups,", rays_checked,
               degenerate_seen);
      $display("with lens and screen extremes, stalls and a full-rate stretch.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
